// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the line clipper RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/ilrc_pkg.sv =====
// Package for the infinite line rectangle clipper: word types, constants, the
// divider step function and the empty-rectangle test. Depends on nothing.
package ilrc_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * COORD_W;
   localparam int DIV_BITS = 2;
   localparam int DIV_STAGES = PROD_W / DIV_BITS;
   localparam int ADV_LAT = DIV_STAGES + 2;
   localparam int TOTAL_LAT = 2 * ADV_LAT + 6;

   localparam logic [1:0] REG_LEFT = 2'd0;
   localparam logic [1:0] REG_BOTTOM = 2'd1;
   localparam logic [1:0] REG_RIGHT = 2'd2;
   localparam logic [1:0] REG_TOP = 2'd3;

   localparam logic signed [COORD_W-1:0] LEFT_RESET = -32'sd65536;
   localparam logic signed [COORD_W-1:0] BOTTOM_RESET = -32'sd65536;
   localparam logic signed [COORD_W-1:0] RIGHT_RESET = 32'sd65536;
   localparam logic signed [COORD_W-1:0] TOP_RESET = 32'sd65536;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] through_x;
      logic signed [COORD_W-1:0] through_y;
      logic                      is_ray;
   } req_type;

   typedef struct packed {
      logic                      visible;
      logic signed [COORD_W-1:0] clip_start_x;
      logic signed [COORD_W-1:0] clip_start_y;
      logic signed [COORD_W-1:0] clip_end_x;
      logic signed [COORD_W-1:0] clip_end_y;
   } rsp_type;

   // Segment on a working axis a with the other coordinate b, plus the span of
   // the next step. An endpoint's b is replaced only when its move flag is set.
   typedef struct packed {
      logic                      vis;
      logic                      a_is_y;
      logic signed [COORD_W-1:0] a0;
      logic signed [COORD_W-1:0] b0;
      logic signed [COORD_W-1:0] a1;
      logic signed [COORD_W-1:0] b1;
      logic signed [COORD_W-1:0] lo;
      logic signed [COORD_W-1:0] hi;
      logic                      mv0;
      logic                      mv1;
   } side_type;

   typedef struct packed {
      logic [COORD_W-1:0] rem;
      logic [PROD_W-1:0]  num;
      logic [PROD_W-1:0]  quo;
      logic [COORD_W-1:0] den;
   } div_state_type;

   function automatic div_state_type div_iter(input div_state_type s);
      div_state_type r;
      logic [COORD_W:0] t;
      r = s;
      for (int i = 0; i < DIV_BITS; i++) begin
         t = {r.rem, r.num[PROD_W-1]};
         r.num = {r.num[PROD_W-2:0], 1'b0};
         if (t >= {1'b0, r.den}) begin
            t = t - {1'b0, r.den};
            r.quo = {r.quo[PROD_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[PROD_W-2:0], 1'b0};
         end
         r.rem = t[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic logic rect_empty(input logic signed [COORD_W-1:0] l,
                                       input logic signed [COORD_W-1:0] b,
                                       input logic signed [COORD_W-1:0] r,
                                       input logic signed [COORD_W-1:0] t);
      return (l == r && b == t) || l > r || b > t;
   endfunction

endpackage

// ===== hw/rtl/ilrc_div.sv =====
// Pipelined unsigned divider, two quotient bits per stage.
// Depends on ilrc_pkg.
module ilrc_div (
   input  logic                          clock,
   input  logic [ilrc_pkg::PROD_W-1:0]   num,
   input  logic [ilrc_pkg::COORD_W-1:0]  den,
   output logic [ilrc_pkg::PROD_W-1:0]   quo
);
   import ilrc_pkg::*;

   div_state_type stage_ff [DIV_STAGES];
   div_state_type first_in;

   always_comb begin
      first_in.rem = '0;
      first_in.num = num;
      first_in.quo = '0;
      first_in.den = den;
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= div_iter(first_in);
      for (int s = 1; s < DIV_STAGES; s++) begin
         stage_ff[s] <= div_iter(stage_ff[s-1]);
      end
   end

   assign quo = stage_ff[DIV_STAGES-1].quo;

endmodule

// ===== hw/rtl/ilrc_adv.sv =====
// Moves up to two endpoints: b' = sat(b + trunc(m * n / den)), one multiply
// stage, a pipelined divider per endpoint and a saturating add stage.
// Depends on ilrc_pkg, ilrc_div and assert_macros.svh.
`include "assert_macros.svh"
module ilrc_adv (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  ilrc_pkg::side_type                  in_side,
   input  logic signed [ilrc_pkg::DIFF_W-1:0]  m,
   input  logic signed [ilrc_pkg::DIFF_W-1:0]  n0,
   input  logic signed [ilrc_pkg::DIFF_W-1:0]  n1,
   input  logic signed [ilrc_pkg::DIFF_W-1:0]  den,
   output logic                                out_valid,
   output ilrc_pkg::side_type                  out_side
);
   import ilrc_pkg::*;

   typedef struct packed {
      side_type side;
      logic     neg0;
      logic     neg1;
   } adv_tag_type;

   logic [COORD_W-1:0] m_mag, n0_mag, n1_mag, den_mag;
   logic [DIFF_W-1:0]  m_abs, n0_abs, n1_abs, den_abs;
   logic [PROD_W-1:0]  p0_ff, p1_ff;
   logic [COORD_W-1:0] den_ff;
   adv_tag_type        tag_ff, tag_in;
   adv_tag_type        line_ff [DIV_STAGES];
   logic               valid_ff [DIV_STAGES+1];
   logic [PROD_W-1:0]  q0, q1;
   side_type           out_in, out_ff;
   logic               out_valid_ff;

   function automatic logic signed [COORD_W-1:0] sat_add(
         input logic signed [COORD_W-1:0] base,
         input logic [PROD_W-1:0] q,
         input logic neg);
      logic signed [COORD_W+3:0] s;
      logic signed [COORD_W+3:0] qs;
      if ((|q[PROD_W-1:COORD_W+2]) || (q[COORD_W+1] && (|q[COORD_W:0]))) begin
         return neg ? COORD_MIN : COORD_MAX;
      end
      qs = {2'b00, q[COORD_W+1:0]};
      s = {{4{base[COORD_W-1]}}, base} + (neg ? -qs : qs);
      if (s > $signed({{4{1'b0}}, COORD_MAX})) begin
         return COORD_MAX;
      end else if (s < $signed({{4{1'b1}}, COORD_MIN})) begin
         return COORD_MIN;
      end
      return s[COORD_W-1:0];
   endfunction

   always_comb begin
      m_abs = m[DIFF_W-1] ? -m : m;
      n0_abs = n0[DIFF_W-1] ? -n0 : n0;
      n1_abs = n1[DIFF_W-1] ? -n1 : n1;
      den_abs = den[DIFF_W-1] ? -den : den;
      m_mag = m_abs[COORD_W-1:0];
      n0_mag = n0_abs[COORD_W-1:0];
      n1_mag = n1_abs[COORD_W-1:0];
      den_mag = den_abs[COORD_W-1:0];
      tag_in.side = in_side;
      tag_in.neg0 = m[DIFF_W-1] ^ n0[DIFF_W-1] ^ den[DIFF_W-1];
      tag_in.neg1 = m[DIFF_W-1] ^ n1[DIFF_W-1] ^ den[DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      p0_ff <= m_mag * n0_mag;
      p1_ff <= m_mag * n1_mag;
      den_ff <= den_mag;
      tag_ff <= tag_in;
      line_ff[0] <= tag_ff;
      for (int s = 1; s < DIV_STAGES; s++) begin
         line_ff[s] <= line_ff[s-1];
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= DIV_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[DIV_STAGES];
      end
   end

   ilrc_div u_div0 (.clock(clock), .num(p0_ff), .den(den_ff), .quo(q0));
   ilrc_div u_div1 (.clock(clock), .num(p1_ff), .den(den_ff), .quo(q1));

   always_comb begin
      out_in = line_ff[DIV_STAGES-1].side;
      if (out_in.mv0) begin
         out_in.b0 = sat_add(out_in.b0, q0, line_ff[DIV_STAGES-1].neg0);
      end
      if (out_in.mv1) begin
         out_in.b1 = sat_add(out_in.b1, q1, line_ff[DIV_STAGES-1].neg1);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_side = out_ff;

   `ASSERT_IMPLIES(a_adv_latency, clock, reset, out_valid_ff, $past(in_valid, ADV_LAT))

endmodule

// ===== hw/rtl/infinite_line_rect_clip_core.sv =====
// Top level of the infinite line / ray rectangle clipper.
// Depends on ilrc_pkg, ilrc_adv and assert_macros.svh.
//
//   Channel   Ports                         Handshake
//   request   start, busy, req_word         taken when start and not busy
//   response  rsp_valid, rsp_word           one-cycle strobe, never held off
//   config    csr_valid, csr_ready, csr_*   written when valid and ready
//
// One word enters every cycle; busy is never raised and csr_ready is always high.
// Latency comes from the two chained 32-stage dividers (span fit, then span cut)
// and the registered stages around them.
// Synchronous reset clears the valid bits and restores the rectangle.
`include "assert_macros.svh"
module infinite_line_rect_clip_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ilrc_pkg::req_type             req_word,
   output logic                          rsp_valid,
   output ilrc_pkg::rsp_type             rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [ilrc_pkg::COORD_W-1:0]  csr_data
);
   import ilrc_pkg::*;

   logic signed [COORD_W-1:0] left_ff, bottom_ff, right_ff, top_ff;

   // stage 1: ray shrink
   logic                      s1_valid_ff, s1_empty_ff;
   logic signed [COORD_W-1:0] s1_x0_ff, s1_y0_ff, s1_x1_ff, s1_y1_ff;
   logic signed [COORD_W-1:0] s1_l_ff, s1_b_ff, s1_r_ff, s1_t_ff;
   logic signed [COORD_W-1:0] s1_l_in, s1_b_in, s1_r_in, s1_t_in;
   // stage 2: extents
   logic                      s2_valid_ff, s2_empty_ff;
   logic signed [COORD_W-1:0] s2_x0_ff, s2_y0_ff, s2_x1_ff, s2_y1_ff;
   logic signed [COORD_W-1:0] s2_l_ff, s2_b_ff, s2_r_ff, s2_t_ff;
   logic [COORD_W-1:0]        s2_ax_ff, s2_ay_ff, s2_w_ff, s2_h_ff;
   logic signed [DIFF_W-1:0]  dx, dy, dw, dh;
   // stage 3: cross products
   logic                      s3_valid_ff, s3_empty_ff;
   logic signed [COORD_W-1:0] s3_x0_ff, s3_y0_ff, s3_x1_ff, s3_y1_ff;
   logic signed [COORD_W-1:0] s3_l_ff, s3_b_ff, s3_r_ff, s3_t_ff;
   logic [PROD_W-1:0]         s3_ph_ff, s3_pw_ff;
   // stage 4: span fit setup
   logic                      s4_valid_ff;
   side_type                  s4_side_ff, s4_side_in;
   logic signed [DIFF_W-1:0]  s4_m_ff, s4_n0_ff, s4_n1_ff, s4_den_ff;
   logic signed [DIFF_W-1:0]  s4_m_in, s4_n0_in, s4_n1_in, s4_den_in;
   // fit result and stage 5: span cut setup
   logic                      fit_valid;
   side_type                  fit_side;
   logic                      s5_valid_ff;
   side_type                  s5_side_ff, s5_side_in;
   logic signed [DIFF_W-1:0]  s5_m_ff, s5_n0_ff, s5_n1_ff, s5_den_ff;
   logic signed [DIFF_W-1:0]  s5_m_in, s5_n0_in, s5_n1_in, s5_den_in;
   // cut result and response register
   logic                      cut_valid;
   side_type                  cut_side;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_zero, cut_on_edge;

   logic accept;
   assign accept = start && !busy;
   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= LEFT_RESET;
         bottom_ff <= BOTTOM_RESET;
         right_ff <= RIGHT_RESET;
         top_ff <= TOP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LEFT: left_ff <= csr_data;
            REG_BOTTOM: bottom_ff <= csr_data;
            REG_RIGHT: right_ff <= csr_data;
            REG_TOP: top_ff <= csr_data;
            default: left_ff <= left_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= fit_valid;
         rsp_valid_ff <= cut_valid;
      end
   end

   // A ray keeps only the part of the rectangle beyond its start point.
   always_comb begin
      s1_l_in = left_ff;
      s1_b_in = bottom_ff;
      s1_r_in = right_ff;
      s1_t_in = top_ff;
      if (req_word.is_ray) begin
         if (req_word.start_x <= req_word.through_x && left_ff <= req_word.start_x) begin
            s1_l_in = req_word.start_x;
         end
         if (req_word.start_x > req_word.through_x && right_ff > req_word.start_x) begin
            s1_r_in = req_word.start_x;
         end
         if (req_word.start_y <= req_word.through_y && bottom_ff <= req_word.start_y) begin
            s1_b_in = req_word.start_y;
         end
         if (req_word.start_y > req_word.through_y && top_ff > req_word.start_y) begin
            s1_t_in = req_word.start_y;
         end
      end
   end

   always_comb begin
      dx = {s1_x0_ff[COORD_W-1], s1_x0_ff} - {s1_x1_ff[COORD_W-1], s1_x1_ff};
      dy = {s1_y0_ff[COORD_W-1], s1_y0_ff} - {s1_y1_ff[COORD_W-1], s1_y1_ff};
      dw = {s1_r_ff[COORD_W-1], s1_r_ff} - {s1_l_ff[COORD_W-1], s1_l_ff};
      dh = {s1_t_ff[COORD_W-1], s1_t_ff} - {s1_b_ff[COORD_W-1], s1_b_ff};
   end

   always_ff @(posedge clock) begin
      s1_empty_ff <= rect_empty(left_ff, bottom_ff, right_ff, top_ff);
      s1_x0_ff <= req_word.start_x;
      s1_y0_ff <= req_word.start_y;
      s1_x1_ff <= req_word.through_x;
      s1_y1_ff <= req_word.through_y;
      s1_l_ff <= s1_l_in;
      s1_b_ff <= s1_b_in;
      s1_r_ff <= s1_r_in;
      s1_t_ff <= s1_t_in;

      s2_empty_ff <= s1_empty_ff || rect_empty(s1_l_ff, s1_b_ff, s1_r_ff, s1_t_ff);
      s2_x0_ff <= s1_x0_ff;
      s2_y0_ff <= s1_y0_ff;
      s2_x1_ff <= s1_x1_ff;
      s2_y1_ff <= s1_y1_ff;
      s2_l_ff <= s1_l_ff;
      s2_b_ff <= s1_b_ff;
      s2_r_ff <= s1_r_ff;
      s2_t_ff <= s1_t_ff;
      s2_ax_ff <= dx[DIFF_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      s2_ay_ff <= dy[DIFF_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      s2_w_ff <= dw[COORD_W-1:0];
      s2_h_ff <= dh[COORD_W-1:0];

      s3_empty_ff <= s2_empty_ff;
      s3_x0_ff <= s2_x0_ff;
      s3_y0_ff <= s2_y0_ff;
      s3_x1_ff <= s2_x1_ff;
      s3_y1_ff <= s2_y1_ff;
      s3_l_ff <= s2_l_ff;
      s3_b_ff <= s2_b_ff;
      s3_r_ff <= s2_r_ff;
      s3_t_ff <= s2_t_ff;
      s3_ph_ff <= s2_ax_ff * s2_h_ff;
      s3_pw_ff <= s2_ay_ff * s2_w_ff;

      s4_side_ff <= s4_side_in;
      s4_m_ff <= s4_m_in;
      s4_n0_ff <= s4_n0_in;
      s4_n1_ff <= s4_n1_in;
      s4_den_ff <= s4_den_in;

      s5_side_ff <= s5_side_in;
      s5_m_ff <= s5_m_in;
      s5_n0_ff <= s5_n0_in;
      s5_n1_ff <= s5_n1_in;
      s5_den_ff <= s5_den_in;

      rsp_ff <= rsp_in;
   end

   // Major axis choice, then the line is stretched across that axis's span.
   always_comb begin
      logic                      hmaj, pos;
      logic signed [COORD_W-1:0] a0, b0, a1, b1, flo, fhi;
      hmaj = s3_ph_ff > s3_pw_ff;
      a0 = hmaj ? s3_x0_ff : s3_y0_ff;
      b0 = hmaj ? s3_y0_ff : s3_x0_ff;
      a1 = hmaj ? s3_x1_ff : s3_y1_ff;
      b1 = hmaj ? s3_y1_ff : s3_x1_ff;
      flo = hmaj ? s3_l_ff : s3_b_ff;
      fhi = hmaj ? s3_r_ff : s3_t_ff;
      s4_den_in = {a1[COORD_W-1], a1} - {a0[COORD_W-1], a0};
      s4_m_in = {b1[COORD_W-1], b1} - {b0[COORD_W-1], b0};
      pos = s4_den_in > 0;
      s4_side_in.vis = !s3_empty_ff && s4_den_in != 0;
      s4_side_in.a_is_y = !hmaj;
      s4_side_in.a0 = pos ? flo : fhi;
      s4_side_in.a1 = pos ? fhi : flo;
      s4_side_in.b0 = b0;
      s4_side_in.b1 = b1;
      s4_side_in.lo = hmaj ? s3_b_ff : s3_l_ff;
      s4_side_in.hi = hmaj ? s3_t_ff : s3_r_ff;
      s4_side_in.mv0 = 1'b1;
      s4_side_in.mv1 = 1'b1;
      s4_n0_in = {s4_side_in.a0[COORD_W-1], s4_side_in.a0} - {a0[COORD_W-1], a0};
      s4_n1_in = {s4_side_in.a1[COORD_W-1], s4_side_in.a1} - {a1[COORD_W-1], a1};
   end

   ilrc_adv u_fit (
      .clock(clock), .reset(reset),
      .in_valid(s4_valid_ff), .in_side(s4_side_ff),
      .m(s4_m_ff), .n0(s4_n0_ff), .n1(s4_n1_ff), .den(s4_den_ff),
      .out_valid(fit_valid), .out_side(fit_side)
   );

   // The cut works on the other axis: the fitted b becomes the new a.
   always_comb begin
      logic signed [COORD_W-1:0] ca0, ca1, cb0, cb1, lo, hi;
      logic                      reject;
      ca0 = fit_side.b0;
      ca1 = fit_side.b1;
      cb0 = fit_side.a0;
      cb1 = fit_side.a1;
      lo = fit_side.lo;
      hi = fit_side.hi;
      reject = (ca0 <= lo && ca1 <= lo) || (ca0 >= hi && ca1 >= hi);
      s5_den_in = {ca1[COORD_W-1], ca1} - {ca0[COORD_W-1], ca0};
      s5_m_in = {cb1[COORD_W-1], cb1} - {cb0[COORD_W-1], cb0};
      s5_side_in.vis = fit_side.vis && !reject;
      s5_side_in.a_is_y = !fit_side.a_is_y;
      s5_side_in.a0 = ca0;
      s5_side_in.a1 = ca1;
      s5_side_in.b0 = cb0;
      s5_side_in.b1 = cb1;
      s5_side_in.lo = lo;
      s5_side_in.hi = hi;
      s5_side_in.mv0 = 1'b0;
      s5_side_in.mv1 = 1'b0;
      s5_n0_in = '0;
      s5_n1_in = '0;
      if (s5_den_in > 0) begin
         if (ca0 < lo) begin
            s5_side_in.mv0 = 1'b1;
            s5_side_in.a0 = lo;
            s5_n0_in = {lo[COORD_W-1], lo} - {ca0[COORD_W-1], ca0};
         end
         if (ca1 > hi) begin
            s5_side_in.mv1 = 1'b1;
            s5_side_in.a1 = hi;
            s5_n1_in = {hi[COORD_W-1], hi} - {ca1[COORD_W-1], ca1};
         end
      end else if (s5_den_in < 0) begin
         if (ca0 > hi) begin
            s5_side_in.mv0 = 1'b1;
            s5_side_in.a0 = hi;
            s5_n0_in = {hi[COORD_W-1], hi} - {ca0[COORD_W-1], ca0};
         end
         if (ca1 < lo) begin
            s5_side_in.mv1 = 1'b1;
            s5_side_in.a1 = lo;
            s5_n1_in = {lo[COORD_W-1], lo} - {ca1[COORD_W-1], ca1};
         end
      end
   end

   ilrc_adv u_cut (
      .clock(clock), .reset(reset),
      .in_valid(s5_valid_ff), .in_side(s5_side_ff),
      .m(s5_m_ff), .n0(s5_n0_ff), .n1(s5_n1_ff), .den(s5_den_ff),
      .out_valid(cut_valid), .out_side(cut_side)
   );

   always_comb begin
      rsp_in.visible = cut_side.vis;
      rsp_in.clip_start_x = cut_side.a_is_y ? cut_side.b0 : cut_side.a0;
      rsp_in.clip_start_y = cut_side.a_is_y ? cut_side.a0 : cut_side.b0;
      rsp_in.clip_end_x = cut_side.a_is_y ? cut_side.b1 : cut_side.a1;
      rsp_in.clip_end_y = cut_side.a_is_y ? cut_side.a1 : cut_side.b1;
      if (!cut_side.vis) begin
         rsp_in.clip_start_x = '0;
         rsp_in.clip_start_y = '0;
         rsp_in.clip_end_x = '0;
         rsp_in.clip_end_y = '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   assign rsp_zero = rsp_ff.clip_start_x == 0 && rsp_ff.clip_start_y == 0 &&
                     rsp_ff.clip_end_x == 0 && rsp_ff.clip_end_y == 0;
   assign cut_on_edge = cut_side.a0 == cut_side.lo || cut_side.a0 == cut_side.hi;

   `ASSERT_IMPLIES(a_rsp_latency, clock, reset, rsp_valid_ff, $past(accept, TOTAL_LAT))
   `ASSERT_IMPLIES(a_invisible_zero, clock, reset, rsp_valid_ff && !rsp_ff.visible, rsp_zero)
   `ASSERT_IMPLIES(a_cut_span, clock, reset, cut_valid && cut_side.vis && cut_side.mv0, cut_on_edge)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for infinite_line_rect_clip_core: line and ray clipping.
// Depends on ilrc_pkg and the RTL; predicts each clipped segment in 64-bit and 128-bit math.
`timescale 1ns / 1ps
module testbench;
   import ilrc_pkg::*;

   localparam int CLIP_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_word = '0;
   logic rsp_valid;
   rsp_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = REG_LEFT;
   logic [COORD_W-1:0] csr_data = '0;

   logic signed [31:0] box_left, box_bottom, box_right, box_top;
   rsp_type clip_expected[$];
   int error_count = 0;
   longint cycle_count = 0;

   infinite_line_rect_clip_core DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Saturating move of one endpoint: base + trunc(m * n / den).
   function automatic logic signed [31:0] move_coord(input longint base, input longint m,
                                                     input longint n, input longint den);
      logic neg;
      logic [127:0] q;
      longint r;
      neg = ((m < 0) != (n < 0)) != (den < 0);
      q = (128'(m < 0 ? -m : m) * 128'(n < 0 ? -n : n)) / 128'(den < 0 ? -den : den);
      if (q > 128'h2_0000_0000) return neg ? COORD_MIN : COORD_MAX;
      r = neg ? base - longint'(q) : base + longint'(q);
      if (r > 64'sd2147483647) return COORD_MAX;
      if (r < -64'sd2147483648) return COORD_MIN;
      return r[31:0];
   endfunction

   function automatic logic box_empty(input longint l, input longint b, input longint r,
                                      input longint t);
      return (l == r && b == t) || l > r || b > t;
   endfunction

   // Stretch the segment across [lo, hi] on its a axis.
   function automatic logic fit_span(inout logic signed [31:0] a0, b0, a1, b1,
                                     input logic signed [31:0] lo, hi);
      longint da, db;
      da = longint'(a1) - a0;
      db = longint'(b1) - b0;
      if (da == 0) return 1'b0;
      if (da > 0) begin
         b0 = move_coord(b0, db, longint'(lo) - a0, da); a0 = lo;
         b1 = move_coord(b1, db, longint'(hi) - a1, da); a1 = hi;
      end else begin
         b0 = move_coord(b0, db, longint'(hi) - a0, da); a0 = hi;
         b1 = move_coord(b1, db, longint'(lo) - a1, da); a1 = lo;
      end
      return 1'b1;
   endfunction

   function automatic logic cut_span(inout logic signed [31:0] a0, b0, a1, b1,
                                     input logic signed [31:0] lo, hi);
      longint da, db;
      if (a0 <= lo && a1 <= lo) return 1'b0;
      if (a0 >= hi && a1 >= hi) return 1'b0;
      da = longint'(a1) - a0;
      db = longint'(b1) - b0;
      if (da == 0) return 1'b1;
      if (da > 0) begin
         if (a0 < lo) begin b0 = move_coord(b0, db, longint'(lo) - a0, da); a0 = lo; end
         if (a1 > hi) begin b1 = move_coord(b1, db, longint'(hi) - a1, da); a1 = hi; end
      end else begin
         if (a0 > hi) begin b0 = move_coord(b0, db, longint'(hi) - a0, da); a0 = hi; end
         if (a1 < lo) begin b1 = move_coord(b1, db, longint'(lo) - a1, da); a1 = lo; end
      end
      return 1'b1;
   endfunction

   function automatic rsp_type predict_clip(input req_type w);
      logic signed [31:0] x0, y0, x1, y1, l, b, r, t;
      logic [63:0] ax, ay, wd, ht;
      logic [127:0] px, py;
      logic vis;
      rsp_type o;
      x0 = w.start_x; y0 = w.start_y; x1 = w.through_x; y1 = w.through_y;
      l = box_left; b = box_bottom; r = box_right; t = box_top;
      vis = 1'b0;
      if (!box_empty(l, b, r, t)) begin
         if (w.is_ray) begin
            if (x0 <= x1 && l <= x0) l = x0;
            if (x0 > x1 && r > x0) r = x0;
            if (y0 <= y1 && b <= y0) b = y0;
            if (y0 > y1 && t > y0) t = y0;
         end
         if (!box_empty(l, b, r, t)) begin
            ax = (x0 > x1) ? longint'(x0) - x1 : longint'(x1) - x0;
            ay = (y0 > y1) ? longint'(y0) - y1 : longint'(y1) - y0;
            wd = longint'(r) - l;
            ht = longint'(t) - b;
            px = 128'(ax) * 128'(ht);
            py = 128'(ay) * 128'(wd);
            if (px > py) begin
               vis = fit_span(x0, y0, x1, y1, l, r);
               if (vis) vis = cut_span(y0, x0, y1, x1, b, t);
            end else begin
               vis = fit_span(y0, x0, y1, x1, b, t);
               if (vis) vis = cut_span(x0, y0, x1, y1, l, r);
            end
         end
      end
      o.visible = vis;
      o.clip_start_x = vis ? x0 : 32'sd0;
      o.clip_start_y = vis ? y0 : 32'sd0;
      o.clip_end_x = vis ? x1 : 32'sd0;
      o.clip_end_y = vis ? y1 : 32'sd0;
      return o;
   endfunction

   // Result checker: every strobed word is matched against the oldest prediction.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (clip_expected.size() == 0) begin
            $error("unexpected result word");
            error_count++;
         end else begin
            rsp_type e;
            e = clip_expected.pop_front();
            if (rsp_word.visible !== e.visible) begin
               $error("visible: expected %0d actual %0d", e.visible, rsp_word.visible);
               error_count++;
            end
            if (rsp_word.clip_start_x !== e.clip_start_x) begin
               $error("clip_start_x: expected %0d actual %0d", e.clip_start_x,
                      rsp_word.clip_start_x);
               error_count++;
            end
            if (rsp_word.clip_start_y !== e.clip_start_y) begin
               $error("clip_start_y: expected %0d actual %0d", e.clip_start_y,
                      rsp_word.clip_start_y);
               error_count++;
            end
            if (rsp_word.clip_end_x !== e.clip_end_x) begin
               $error("clip_end_x: expected %0d actual %0d", e.clip_end_x,
                      rsp_word.clip_end_x);
               error_count++;
            end
            if (rsp_word.clip_end_y !== e.clip_end_y) begin
               $error("clip_end_y: expected %0d actual %0d", e.clip_end_y,
                      rsp_word.clip_end_y);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CLIP_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Idle length: mostly none, sometimes a few cycles, rarely a long pause.
   function automatic int gap_len();
      int n;
      n = $urandom_range(0, 9);
      if (n < 6) n = 0;
      else if (n < 9) n = $urandom_range(1, 3);
      else n = $urandom_range(4, 40);
      return n;
   endfunction

   // Sends one word; start stays high across back-to-back words.
   task automatic send_line(input req_type w, input logic allow_gap);
      int n;
      n = 0;
      if (allow_gap && $urandom_range(0, 3) == 0) n = gap_len();
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      clip_expected.push_back(predict_clip(w));
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (clip_expected.size() != 0) @(negedge clock);
      repeat (2 * ADV_LAT + 16) @(negedge clock);
   endtask

   // Valid stays high across consecutive writes; set_box drops it at the end.
   task automatic write_reg(input logic [1:0] idx, input logic signed [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      case (idx)
         REG_LEFT: box_left = v;
         REG_BOTTOM: box_bottom = v;
         REG_RIGHT: box_right = v;
         default: box_top = v;
      endcase
   endtask

   task automatic set_box(input logic signed [31:0] l, b, r, t);
      write_reg(REG_LEFT, l);
      write_reg(REG_BOTTOM, b);
      write_reg(REG_RIGHT, r);
      write_reg(REG_TOP, t);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_line(input logic signed [31:0] x0, y0, x1, y1,
                                         input logic ray);
      req_type w;
      w.start_x = x0; w.start_y = y0; w.through_x = x1; w.through_y = y1;
      w.is_ray = ray;
      return w;
   endfunction

   function automatic logic signed [31:0] pick_coord(input logic signed [31:0] lo,
                                                     input logic signed [31:0] hi);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         2: return $urandom_range(0, 1) ? lo : hi;
         default: return 32'(longint'(lo) - (longint'(hi) - lo) / 2
                         + longint'($urandom_range(0, 32'hffff_ffff))
                           % ((longint'(hi) - lo) * 2 + 1));
      endcase
   endfunction

   task automatic test_directed();
      send_line(make_line(-32'sd131072, 0, 32'sd131072, 0, 0), 0);
      send_line(make_line(0, -32'sd131072, 0, 32'sd131072, 0), 0);
      send_line(make_line(0, 0, 32'sd65536, 32'sd32768, 1), 0);
      send_line(make_line(0, 0, -32'sd65536, -32'sd32768, 1), 0);
      send_line(make_line(5, 5, 5, 5, 0), 0);
      send_line(make_line(5, 5, 5, 5, 1), 0);
      send_line(make_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0), 0);
      send_line(make_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1), 0);
      send_line(make_line(COORD_MAX, 0, COORD_MAX, 1, 0), 0);
      send_line(make_line(-32'sd65536, 32'sd200000, 32'sd65536, 32'sd200000, 0), 0);
      send_line(make_line(32'sd200000, 0, 32'sd300000, 0, 1), 0);
      send_line(make_line(0, 0, 32'sd65536, 32'sd65536, 0), 0);
      send_line(make_line(1, -1, -1, 1, 1), 0);
      drain();
      set_box(32'sd65536, 0, 32'sd65536, 32'sd65536);
      send_line(make_line(0, 0, 32'sd131072, 32'sd131072, 0), 0);
      drain();
      set_box(32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536);
      send_line(make_line(0, 0, 32'sd131072, 32'sd131072, 0), 0);
      drain();
      set_box(32'sd65536, 0, -32'sd65536, 32'sd65536);
      send_line(make_line(0, 0, 32'sd131072, 32'sd131072, 0), 0);
      drain();
      set_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_line(make_line(0, 0, 1, 3, 0), 0);
      send_line(make_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1), 0);
      send_line(make_line(-7, 3, 9, -4, 0), 0);
      drain();
   endtask

   task automatic random_phase(input logic signed [31:0] l, b, r, t, input int count);
      logic signed [31:0] lo, hi;
      set_box(l, b, r, t);
      lo = (l < b) ? l : b;
      hi = (r > t) ? r : t;
      if (lo > hi) begin lo = -32'sd65536; hi = 32'sd65536; end
      for (int i = 0; i < count; i++)
         send_line(make_line(pick_coord(lo, hi), pick_coord(lo, hi), pick_coord(lo, hi),
                             pick_coord(lo, hi), $urandom_range(0, 1)), 1);
      drain();
   endtask

   task automatic test_random();
      random_phase(-32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 300);
      random_phase(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 250);
      random_phase(-32'sd100, 32'sd5000, 32'sd300, 32'sd9000, 200);
      random_phase(32'sd1000, -32'sd1000000, 32'sd1001, 32'sd1000000, 150);
      for (int k = 0; k < 9; k++)
         random_phase($urandom, $urandom, $urandom, $urandom, 50);
      random_phase(32'sd10, -32'sd10, 32'sd10, 32'sd10, 50);
   endtask

   initial begin
      box_left = LEFT_RESET; box_bottom = BOTTOM_RESET;
      box_right = RIGHT_RESET; box_top = TOP_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      if (error_count == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ilrc_pkg.sv
hw/rtl/ilrc_div.sv
hw/rtl/ilrc_adv.sv
hw/rtl/infinite_line_rect_clip_core.sv
sim/testbench.sv
